// ===== rtl/core/pst_pkg.sv =====
// shared types and constants for the patterned shape pixel test
// depends on nothing
`default_nettype none
package pst_pkg;
    localparam int unsigned NUM_LANES = 5;
    localparam int unsigned REM_BITS  = 8;
    localparam int unsigned DATA_BITS = 32;
    localparam int unsigned ADDR_BITS = 5;

    // remainder lanes
    localparam int unsigned LANE_X      = 0;
    localparam int unsigned LANE_Y      = 1;
    localparam int unsigned LANE_SUM    = 2;
    localparam int unsigned LANE_DIFF   = 3;
    localparam int unsigned LANE_XSHIFT = 4;

    // register indexes
    localparam logic [2:0] REG_SHAPE_MODE   = 3'd0;
    localparam logic [2:0] REG_PATTERN_KIND = 3'd1;
    localparam logic [2:0] REG_SPACING      = 3'd2;
    localparam logic [2:0] REG_ORIGIN_X     = 3'd3;
    localparam logic [2:0] REG_ORIGIN_Y     = 3'd4;
    localparam logic [2:0] REG_EXTENT_X     = 3'd5;
    localparam logic [2:0] REG_EXTENT_Y     = 3'd6;

    typedef enum logic [2:0] {
        PAT_DOTS   = 3'd0,
        PAT_HLINES = 3'd1,
        PAT_VLINES = 3'd2,
        PAT_GRID   = 3'd3,
        PAT_DIAG_L = 3'd4,
        PAT_DIAG_R = 3'd5,
        PAT_CROSS  = 3'd6,
        PAT_BRICK  = 3'd7
    } pattern_t;

    localparam logic [REM_BITS-1:0] SPACING_RESET = 8'd2;
    localparam logic [REM_BITS-1:0] SPACING_MIN   = 8'd2;
endpackage
`default_nettype wire

// ===== rtl/core/pst_front.sv =====
// front stages: shape geometry and dividend magnitudes for the remainder chain
// depends on pst_pkg
`default_nettype none
module pst_front #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [COORD_BITS-1:0] pixel_x,
    input  wire logic [COORD_BITS-1:0] pixel_y,
    input  wire logic                  shape_mode,
    input  wire logic [COORD_BITS-1:0] origin_x,
    input  wire logic [COORD_BITS-1:0] origin_y,
    input  wire logic [COORD_BITS-1:0] extent_x,
    input  wire logic [COORD_BITS-1:0] extent_y,
    input  wire logic [pst_pkg::REM_BITS-1:0] half_sp,
    output logic                       out_valid,
    output logic                       out_in_shape,
    output logic [pst_pkg::NUM_LANES-1:0][COORD_BITS:0] out_mag
);
    localparam int W  = COORD_BITS + 1;
    localparam int SQ = 2 * W;

    logic                 v1_reg, v2_reg;
    logic                 rect1_reg, rect2_reg;
    logic                 rneg1_reg, rneg2_reg;
    logic signed [W-1:0]  dx1_reg, dy1_reg;
    logic signed [COORD_BITS-1:0] r1_reg;
    logic [SQ-1:0]        sqx2_reg, sqy2_reg, rr2_reg;
    logic [pst_pkg::NUM_LANES-1:0][W-1:0] mag1_reg, mag2_reg;

    logic signed [W-1:0] xs, ys, val [pst_pkg::NUM_LANES];
    logic rect_next;
    logic [pst_pkg::NUM_LANES-1:0][W-1:0] mag_next;

    always_comb begin
        xs = W'($signed(pixel_x));
        ys = W'($signed(pixel_y));
        val[pst_pkg::LANE_X]      = xs;
        val[pst_pkg::LANE_Y]      = ys;
        val[pst_pkg::LANE_SUM]    = xs + ys;
        val[pst_pkg::LANE_DIFF]   = xs - ys;
        val[pst_pkg::LANE_XSHIFT] = xs + $signed({{(W-pst_pkg::REM_BITS){1'b0}}, half_sp});
        for (int i = 0; i < pst_pkg::NUM_LANES; i++) begin
            mag_next[i] = val[i][W-1] ? W'(-val[i]) : W'(val[i]);
        end
        rect_next = ($signed(pixel_x) >= $signed(origin_x)) &&
                    ($signed(pixel_x) <  $signed(extent_x)) &&
                    ($signed(pixel_y) >= $signed(origin_y)) &&
                    ($signed(pixel_y) <  $signed(extent_y));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
        if (en) begin
            rect1_reg <= rect_next;
            rneg1_reg <= extent_x[COORD_BITS-1];
            r1_reg    <= $signed(extent_x);
            dx1_reg   <= xs - W'($signed(origin_x));
            dy1_reg   <= ys - W'($signed(origin_y));
            mag1_reg  <= mag_next;
            rect2_reg <= rect1_reg;
            rneg2_reg <= rneg1_reg;
            sqx2_reg  <= SQ'(SQ'(dx1_reg) * SQ'(dx1_reg));
            sqy2_reg  <= SQ'(SQ'(dy1_reg) * SQ'(dy1_reg));
            rr2_reg   <= SQ'(SQ'(r1_reg) * SQ'(r1_reg));
            mag2_reg  <= mag1_reg;
        end
    end

    logic [SQ:0] dist_sq;
    assign dist_sq      = {1'b0, sqx2_reg} + {1'b0, sqy2_reg};
    assign out_valid    = v2_reg;
    assign out_in_shape = shape_mode ? (!rneg2_reg && (dist_sq <= {1'b0, rr2_reg})) : rect2_reg;
    assign out_mag      = mag2_reg;
endmodule
`default_nettype wire

// ===== rtl/core/pst_cell.sv =====
// one restoring remainder step on every lane, one dividend bit per cell
// depends on pst_pkg
`default_nettype none
module pst_cell #(
    parameter int MAG_BITS = 13,
    parameter int BIT_IDX  = 12
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic [pst_pkg::REM_BITS-1:0] spacing,
    input  wire logic                  in_valid,
    input  wire logic                  in_in_shape,
    input  wire logic [pst_pkg::NUM_LANES-1:0][MAG_BITS-1:0] in_mag,
    input  wire logic [pst_pkg::NUM_LANES-1:0][pst_pkg::REM_BITS-1:0] in_rem,
    output logic                       out_valid,
    output logic                       out_in_shape,
    output logic                       out_q_lsb,
    output logic [pst_pkg::NUM_LANES-1:0][MAG_BITS-1:0] out_mag,
    output logic [pst_pkg::NUM_LANES-1:0][pst_pkg::REM_BITS-1:0] out_rem
);
    logic valid_reg, shape_reg, q_reg;
    logic [pst_pkg::NUM_LANES-1:0][MAG_BITS-1:0] mag_reg;
    logic [pst_pkg::NUM_LANES-1:0][pst_pkg::REM_BITS-1:0] rem_reg, rem_next;
    logic [pst_pkg::NUM_LANES-1:0] q_next;
    logic [pst_pkg::REM_BITS:0] trial [pst_pkg::NUM_LANES];

    always_comb begin
        for (int i = 0; i < pst_pkg::NUM_LANES; i++) begin
            trial[i] = {in_rem[i], in_mag[i][BIT_IDX]};
            q_next[i] = trial[i] >= {1'b0, spacing};
            rem_next[i] = q_next[i] ? pst_pkg::REM_BITS'(trial[i] - {1'b0, spacing})
                                    : pst_pkg::REM_BITS'(trial[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            shape_reg <= in_in_shape;
            mag_reg   <= in_mag;
            rem_reg   <= rem_next;
            q_reg     <= q_next[pst_pkg::LANE_Y];
        end
    end

    assign out_valid    = valid_reg;
    assign out_in_shape = shape_reg;
    assign out_q_lsb    = q_reg;
    assign out_mag      = mag_reg;
    assign out_rem      = rem_reg;
endmodule
`default_nettype wire

// ===== rtl/core/patterned_shape_pixel_test.sv =====
// top level: config registers, front stages, remainder cell chain, pattern select
// depends on pst_pkg, pst_front, pst_cell
// datapath: registered in the front stages and in every chain cell; the pattern select is combinational
// throughput: one transfer per cycle; the whole pipe advances when the output is free
// the chain holds one cell per dividend bit, so its length grows with COORD_BITS
// reset: synchronous active-low aresetn clears valid bits and config (spacing to 2)
`default_nettype none
module patterned_shape_pixel_test #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [COORD_BITS-1:0] s_pixel_x,
    input  wire logic [COORD_BITS-1:0] s_pixel_y,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_paint,
    output logic                       m_in_shape,
    // config port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [pst_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [pst_pkg::DATA_BITS-1:0] pwdata,
    output logic [pst_pkg::DATA_BITS-1:0] prdata,
    output logic                       pready
);
    localparam int MAG_BITS = COORD_BITS + 1;
    localparam int NL = pst_pkg::NUM_LANES;
    localparam int RB = pst_pkg::REM_BITS;

    // config registers
    logic                  shape_mode_reg;
    pst_pkg::pattern_t     pattern_kind_reg;
    logic [RB-1:0]         spacing_reg;
    logic [COORD_BITS-1:0] origin_x_reg, origin_y_reg, extent_x_reg, extent_y_reg;

    logic       wr_en;
    logic [2:0] reg_idx;
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[pst_pkg::ADDR_BITS-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_mode_reg   <= 1'b0;
            pattern_kind_reg <= pst_pkg::PAT_DOTS;
            spacing_reg      <= pst_pkg::SPACING_RESET;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            extent_x_reg     <= '0;
            extent_y_reg     <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                pst_pkg::REG_SHAPE_MODE:   shape_mode_reg   <= pwdata[0];
                pst_pkg::REG_PATTERN_KIND: pattern_kind_reg <= pst_pkg::pattern_t'(pwdata[2:0]);
                pst_pkg::REG_SPACING:      spacing_reg      <= pwdata[RB-1:0];
                pst_pkg::REG_ORIGIN_X:     origin_x_reg     <= pwdata[COORD_BITS-1:0];
                pst_pkg::REG_ORIGIN_Y:     origin_y_reg     <= pwdata[COORD_BITS-1:0];
                pst_pkg::REG_EXTENT_X:     extent_x_reg     <= pwdata[COORD_BITS-1:0];
                pst_pkg::REG_EXTENT_Y:     extent_y_reg     <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // read back, coordinates sign extended to the bus
    always_comb begin
        case (reg_idx)
            pst_pkg::REG_SHAPE_MODE:   prdata = {31'd0, shape_mode_reg};
            pst_pkg::REG_PATTERN_KIND: prdata = {29'd0, pattern_kind_reg};
            pst_pkg::REG_SPACING:      prdata = {24'd0, spacing_reg};
            pst_pkg::REG_ORIGIN_X:     prdata = 32'($signed(origin_x_reg));
            pst_pkg::REG_ORIGIN_Y:     prdata = 32'($signed(origin_y_reg));
            pst_pkg::REG_EXTENT_X:     prdata = 32'($signed(extent_x_reg));
            pst_pkg::REG_EXTENT_Y:     prdata = 32'($signed(extent_y_reg));
            default:                   prdata = '0;
        endcase
    end

    // spacing below two acts as two
    logic [RB-1:0] sp_eff, half_sp;
    assign sp_eff  = (spacing_reg < pst_pkg::SPACING_MIN) ? pst_pkg::SPACING_MIN : spacing_reg;
    assign half_sp = sp_eff >> 1;

    // whole pipe moves unless a result is stuck at the output
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // front: geometry and magnitudes
    logic                        f_valid, f_shape;
    logic [NL-1:0][MAG_BITS-1:0] f_mag;

    pst_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (s_valid),
        .pixel_x      (s_pixel_x),
        .pixel_y      (s_pixel_y),
        .shape_mode   (shape_mode_reg),
        .origin_x     (origin_x_reg),
        .origin_y     (origin_y_reg),
        .extent_x     (extent_x_reg),
        .extent_y     (extent_y_reg),
        .half_sp      (half_sp),
        .out_valid    (f_valid),
        .out_in_shape (f_shape),
        .out_mag      (f_mag)
    );

    // remainder chain, msb of the dividend first; link k feeds cell k
    logic                        c_valid [MAG_BITS+1];
    logic                        c_shape [MAG_BITS+1];
    logic                        c_q     [MAG_BITS+1];
    logic [NL-1:0][MAG_BITS-1:0] c_mag   [MAG_BITS+1];
    logic [NL-1:0][RB-1:0]       c_rem   [MAG_BITS+1];

    assign c_valid[0] = f_valid;
    assign c_shape[0] = f_shape;
    assign c_q[0]     = 1'b0;
    assign c_mag[0]   = f_mag;
    assign c_rem[0]   = '0;

    for (genvar k = 0; k < MAG_BITS; k++) begin : g_cell
        pst_cell #(.MAG_BITS(MAG_BITS), .BIT_IDX(MAG_BITS - 1 - k)) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .en           (en),
            .spacing      (sp_eff),
            .in_valid     (c_valid[k]),
            .in_in_shape  (c_shape[k]),
            .in_mag       (c_mag[k]),
            .in_rem       (c_rem[k]),
            .out_valid    (c_valid[k+1]),
            .out_in_shape (c_shape[k+1]),
            .out_q_lsb    (c_q[k+1]),
            .out_mag      (c_mag[k+1]),
            .out_rem      (c_rem[k+1])
        );
    end

    // pattern select on the final remainders
    logic [NL-1:0] zero;
    logic          match;
    always_comb begin
        for (int i = 0; i < NL; i++) begin
            zero[i] = (c_rem[MAG_BITS][i] == '0);
        end
        case (pattern_kind_reg)
            pst_pkg::PAT_DOTS:   match = zero[pst_pkg::LANE_X] && zero[pst_pkg::LANE_Y];
            pst_pkg::PAT_HLINES: match = zero[pst_pkg::LANE_Y];
            pst_pkg::PAT_VLINES: match = zero[pst_pkg::LANE_X];
            pst_pkg::PAT_GRID:   match = zero[pst_pkg::LANE_X] || zero[pst_pkg::LANE_Y];
            pst_pkg::PAT_DIAG_L: match = zero[pst_pkg::LANE_SUM];
            pst_pkg::PAT_DIAG_R: match = zero[pst_pkg::LANE_DIFF];
            pst_pkg::PAT_CROSS:  match = zero[pst_pkg::LANE_SUM] || zero[pst_pkg::LANE_DIFF];
            pst_pkg::PAT_BRICK:  begin
                // odd rows of bricks shift by half a period
                if (zero[pst_pkg::LANE_Y]) begin
                    match = 1'b1;
                end else if (c_q[MAG_BITS]) begin
                    match = zero[pst_pkg::LANE_XSHIFT];
                end else begin
                    match = zero[pst_pkg::LANE_X];
                end
            end
            default: match = 1'b0;
        endcase
    end

    assign m_valid    = c_valid[MAG_BITS];
    assign m_in_shape = c_shape[MAG_BITS];
    assign m_paint    = c_shape[MAG_BITS] && match;
endmodule
`default_nettype wire

// ===== rtl/core/pst_checker.sv =====
// port-level checker for the patterned shape pixel test, with its bind
// depends on patterned_shape_pixel_test ports only
`default_nettype none
module pst_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic m_paint,
    input wire logic m_in_shape
);
    // a stalled result stays
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_paint) && $stable(m_in_shape))
        else $error("stalled result changed");

    // painting only happens inside the shape
    a_paint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_paint || m_in_shape))
        else $error("paint outside shape");

    // empty output never blocks input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind patterned_shape_pixel_test pst_checker u_pst_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_paint    (m_paint),
    .m_in_shape (m_in_shape)
);
`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for the patterned shape pixel test block
// depends on pst_pkg and patterned_shape_pixel_test from the rtl folder
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = 12;
    localparam int LATENCY = CB + 3;
    localparam int STALL_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CB-1:0] s_pixel_x = '0;
    logic [CB-1:0] s_pixel_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_paint;
    logic m_in_shape;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [pst_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [pst_pkg::DATA_BITS-1:0] pwdata = '0;
    logic [pst_pkg::DATA_BITS-1:0] prdata;
    logic pready;

    patterned_shape_pixel_test #(.COORD_BITS(CB)) dut (.*);

    // configuration copy used by the predictor
    logic circle_mode;
    pst_pkg::pattern_t fill_pattern;
    logic [7:0] period_reg;
    logic signed [CB-1:0] org_x, org_y, ext_x, ext_y;

    typedef struct packed {
        logic paint;
        logic in_shape;
    } pixel_verdict_t;

    pixel_verdict_t verdict_queue[$];
    int errors = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    bit hold_active = 1'b0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    // divisible under truncating remainder
    function automatic bit divides(longint a, longint s);
        return (a % s) == 0;
    endfunction

    function automatic pixel_verdict_t predict_pixel(logic signed [CB-1:0] px,
                                                     logic signed [CB-1:0] py);
        longint x, y, s, dx, dy, r;
        bit in_area, hit;
        pixel_verdict_t v;
        x = px;
        y = py;
        s = (period_reg < 2) ? 2 : period_reg;
        if (circle_mode) begin
            dx = x - org_x;
            dy = y - org_y;
            r = ext_x;
            in_area = (r >= 0) && (dx * dx + dy * dy <= r * r);
        end else begin
            in_area = (x >= org_x) && (x < ext_x) && (y >= org_y) && (y < ext_y);
        end
        case (fill_pattern)
            pst_pkg::PAT_DOTS:   hit = divides(x, s) && divides(y, s);
            pst_pkg::PAT_HLINES: hit = divides(y, s);
            pst_pkg::PAT_VLINES: hit = divides(x, s);
            pst_pkg::PAT_GRID:   hit = divides(x, s) || divides(y, s);
            pst_pkg::PAT_DIAG_L: hit = divides(x + y, s);
            pst_pkg::PAT_DIAG_R: hit = divides(x - y, s);
            pst_pkg::PAT_CROSS:  hit = divides(x + y, s) || divides(x - y, s);
            default: begin
                // brick: odd courses shift by half a period
                if (divides(y, s)) hit = 1'b1;
                else if (((y / s) % 2) != 0) hit = divides(x + s / 2, s);
                else hit = divides(x, s);
            end
        endcase
        v.in_shape = in_area;
        v.paint = in_area && hit;
        return v;
    endfunction

    // apb write: setup then access, update the local register copy on the access edge
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= pst_pkg::ADDR_BITS'(idx * 4);
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            pst_pkg::REG_SHAPE_MODE:   circle_mode = value[0];
            pst_pkg::REG_PATTERN_KIND: fill_pattern = pst_pkg::pattern_t'(value[2:0]);
            pst_pkg::REG_SPACING:      period_reg = value[7:0];
            pst_pkg::REG_ORIGIN_X:     org_x = value[CB-1:0];
            pst_pkg::REG_ORIGIN_Y:     org_y = value[CB-1:0];
            pst_pkg::REG_EXTENT_X:     ext_x = value[CB-1:0];
            default:                   ext_y = value[CB-1:0];
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_shape(bit circ, int ox, int oy, int ex, int ey);
        write_reg(pst_pkg::REG_SHAPE_MODE, circ);
        write_reg(pst_pkg::REG_ORIGIN_X, ox);
        write_reg(pst_pkg::REG_ORIGIN_Y, oy);
        write_reg(pst_pkg::REG_EXTENT_X, ex);
        write_reg(pst_pkg::REG_EXTENT_Y, ey);
    endtask

    task automatic set_pattern(pst_pkg::pattern_t kind, int period);
        write_reg(pst_pkg::REG_PATTERN_KIND, kind);
        write_reg(pst_pkg::REG_SPACING, period);
    endtask

    // sends one pixel; valid stays up across back-to-back transfers
    task automatic send_pixel(logic [CB-1:0] px, logic [CB-1:0] py, bit allow_gap = 1);
        int gap;
        gap = 0;
        if (allow_gap) begin
            if ($urandom_range(0, 99) < 20) gap = $urandom_range(1, 3);
            else if ($urandom_range(0, 99) < 3) gap = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel_x <= px;
        s_pixel_y <= py;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        verdict_queue.push_back(predict_pixel(px, py));
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
    endtask

    // wait for the pipe to drain before touching registers
    task automatic drain();
        stop_sending();
        while (verdict_queue.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    function automatic logic [CB-1:0] rand_coord();
        return CB'($urandom);
    endfunction

    // coordinates near a window so both sides of each bound get hit
    function automatic logic [CB-1:0] near(int centre, int spread);
        return CB'(centre + $signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // reset values: rectangle with empty bounds, dots, spacing 2
    task automatic test_reset_defaults();
        send_pixel(0, 0, 0);
        send_pixel(1, 1, 0);
        drain();
    endtask

    task automatic test_directed_extremes();
        set_shape(0, -2048, -2048, 2047, 2047);
        set_pattern(pst_pkg::PAT_DOTS, 0);
        send_pixel(12'h800, 12'h800);
        send_pixel(12'h7ff, 12'h7fe);
        send_pixel(12'h7fe, 12'h800);
        send_pixel(12'hfff, 12'h000);
        drain();
        // every pattern, odd kinds with spacing 1 (acts as 2) and even kinds with odd spacing 7, negative coords
        for (int k = 0; k < 8; k++) begin
            set_pattern(pst_pkg::pattern_t'(k), (k % 2) ? 1 : 7);
            send_pixel(-7, -3);
            send_pixel(-14, 10);
            drain();
        end
        // circle at the widest radius, and a negative radius
        set_shape(1, 0, 0, 2047, 0);
        set_pattern(pst_pkg::PAT_GRID, 255);
        send_pixel(12'h800, 12'h800);
        send_pixel(12'h7ff, 0);
        drain();
        set_shape(1, 5, 5, -1, 0);
        send_pixel(5, 5);
        drain();
        // inverted rectangle
        set_shape(0, 100, 100, 50, 50);
        send_pixel(75, 75);
        drain();
    endtask

    task automatic test_random_phase(int count, bit circ);
        int ox, oy, ex, ey;
        ox = $signed(rand_coord()) / 2;
        oy = $signed(rand_coord()) / 2;
        if (circ) begin
            ex = $urandom_range(0, 9) == 0 ? -$urandom_range(1, 50) : $urandom_range(0, 300);
            ey = $signed(rand_coord());
        end else begin
            ex = ox + $urandom_range(0, 400) - 20;
            ey = oy + $urandom_range(0, 400) - 20;
        end
        set_shape(circ, ox, oy, ex, ey);
        set_pattern(pst_pkg::pattern_t'($urandom_range(0, 7)),
                    $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 12));
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) send_pixel(rand_coord(), rand_coord());
            else send_pixel(near(circ ? ox : (ox + ex) / 2, 300),
                            near(circ ? oy : (oy + ey) / 2, 300));
        end
        drain();
    endtask

    // long receiver hold-off while the sender keeps offering pixels
    task automatic test_backpressure();
        set_shape(0, -2048, -2048, 2047, 2047);
        set_pattern(pst_pkg::PAT_BRICK, 6);
        hold_off = 1'b1;
        wait (hold_active);
        for (int i = 0; i < 60; i++) send_pixel(rand_coord(), rand_coord(), 0);
        drain();
    endtask

    // receiver ready: random stalls, occasional long ones, long hold-off on request
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            if (hold_off) begin
                hold_active = 1'b1;
                m_ready <= 1'b0;
                repeat (200) @(posedge aclk);
                hold_off = 1'b0;
                hold_active = 1'b0;
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                : $urandom_range(0, 3);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // result checker: compare each transfer with the oldest prediction
    always @(posedge aclk) begin
        pixel_verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_queue.size() == 0) begin
                $error("result transfer with no prediction pending");
                errors++;
            end else begin
                want = verdict_queue.pop_front();
                if (m_paint !== want.paint) begin
                    $error("paint expected %0b actual %0b", want.paint, m_paint);
                    errors++;
                end
                if (m_in_shape !== want.in_shape) begin
                    $error("in_shape expected %0b actual %0b", want.in_shape, m_in_shape);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        circle_mode = 1'b0;
        fill_pattern = pst_pkg::PAT_DOTS;
        period_reg = pst_pkg::SPACING_RESET;
        org_x = '0;
        org_y = '0;
        ext_x = '0;
        ext_y = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed_extremes();
        test_backpressure();
        for (int p = 0; p < 12; p++) test_random_phase(55, p % 2);
        drain();
        if (errors == 0 && verdict_queue.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/pst_pkg.sv
rtl/core/pst_front.sv
rtl/core/pst_cell.sv
rtl/core/patterned_shape_pixel_test.sv
rtl/core/pst_checker.sv
dv/testbench.sv
